@@ design/xor_checked_frame_receiver_core_assert.svh @@
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_core_assert.svh
// Assertion macros for the frame receiver. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define XOR_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Clocked check, held off while reset is asserted
`define XCFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define XCFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define XCFR_ASSERT(lbl, prop, msg)
`define XCFR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ design/xcfr_pkg.sv @@
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types and codes for the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xcfr_pkg;

  // Operation codes of an input item
  localparam logic [1:0] OP_ARM  = 2'd0;
  localparam logic [1:0] OP_BYTE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;

  // Frame status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TIMEOUT  = 2'd1;
  localparam logic [1:0] ST_CHECKSUM = 2'd2;

  // Timeout register value after reset
  localparam logic [15:0] TIMEOUT_RESET = 16'd100;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] out_byte;
    logic [8:0] byte_index;
    logic       frame_done;
    logic [1:0] frame_status;
  } result_t;

endpackage

@@ design/xcfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// xcfr_in_stage
// Input register: holds one item until the engine consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  xcfr_pkg::item_t in_item,
  input  logic           fire,
  output logic           vld,
  output xcfr_pkg::item_t item
);
  import xcfr_pkg::*;

  logic  vld_r;
  logic  vld_nxt;
  item_t item_r;
  logic  load;

  // Take a new item when empty or when the held one is consumed
  assign in_stall = vld_r && !fire;
  assign load     = in_valid && !in_stall;
  assign vld_nxt  = load || (vld_r && !fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign vld  = vld_r;
  assign item = item_r;

endmodule

@@ design/xcfr_engine.sv @@
// ----------------------------------------------------------------------------
// xcfr_engine
// Frame state and per-item logic: arm, byte, tick, checksum and timeout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xor_checked_frame_receiver_core_assert.svh"

module xcfr_engine (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld,
  input  xcfr_pkg::item_t  item,
  input  logic             fire,
  input  logic [15:0]      timeout_ticks,
  output logic             res_has,
  output xcfr_pkg::result_t res
);
  import xcfr_pkg::*;

  logic        recv_r,  recv_nxt;
  logic [8:0]  cnt_r,   cnt_nxt;
  logic [7:0]  len_r,   len_nxt;
  logic [7:0]  xor_r,   xor_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic [9:0]  end_count;
  logic [15:0] ticks_dec;

  assign ticks_dec = ticks_r - 16'd1;

  // Next state and result for the held item
  always_comb begin
    recv_nxt  = recv_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    xor_nxt   = xor_r;
    ticks_nxt = ticks_r;
    res_has   = 1'b0;
    res       = '0;
    end_count = '0;
    case (item.operation)
      OP_ARM: begin
        recv_nxt  = 1'b1;
        cnt_nxt   = '0;
        len_nxt   = '0;
        xor_nxt   = '0;
        ticks_nxt = timeout_ticks;
      end
      OP_BYTE: begin
        if (recv_r) begin
          xor_nxt   = xor_r ^ item.rx_byte;
          len_nxt   = (cnt_r == 9'd1) ? item.rx_byte : len_r;
          cnt_nxt   = cnt_r + 9'd1;
          ticks_nxt = timeout_ticks;
          end_count = {2'b00, len_nxt} + 10'd2;
          res_has        = 1'b1;
          res.byte_valid = 1'b1;
          res.out_byte   = item.rx_byte;
          res.byte_index = cnt_r;
          if (cnt_nxt >= 9'd2 && {1'b0, cnt_nxt} >= end_count) begin
            recv_nxt         = 1'b0;
            res.frame_done   = 1'b1;
            res.frame_status = (xor_nxt != 8'd0) ? ST_CHECKSUM : ST_OK;
          end
        end
      end
      OP_TICK: begin
        if (recv_r && ticks_r != 16'd0) begin
          ticks_nxt = ticks_dec;
          if (ticks_dec == 16'd0) begin
            recv_nxt         = 1'b0;
            res_has          = 1'b1;
            res.byte_index   = cnt_r;
            res.frame_done   = 1'b1;
            res.frame_status = ST_TIMEOUT;
          end
        end
      end
      default: begin
        // Unused code: drop the item
      end
    endcase
  end

  // Advance state when the item is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_r  <= 1'b0;
      cnt_r   <= '0;
      len_r   <= '0;
      xor_r   <= '0;
      ticks_r <= '0;
    end else if (fire) begin
      recv_r  <= recv_nxt;
      cnt_r   <= cnt_nxt;
      len_r   <= len_nxt;
      xor_r   <= xor_nxt;
      ticks_r <= ticks_nxt;
    end
  end

  `XCFR_ASSERT(a_done_disarms, (fire && res_has && res.frame_done) |=> !recv_r, "frame end left receiver armed")
  `XCFR_ASSERT(a_arm_clears, (fire && item.operation == OP_ARM) |=> (recv_r && cnt_r == 9'd0 && xor_r == 8'd0), "arm did not restart the frame")
  `XCFR_ASSERT(a_timeout_form, (vld && res_has && !res.byte_valid) |-> (res.frame_done && res.frame_status == ST_TIMEOUT), "byteless result is not a timeout")
  `XCFR_ASSERT_ALWAYS(a_idle_no_result, (!recv_r && item.operation != OP_ARM) |-> !res_has, "result produced while not armed")

endmodule

@@ design/xcfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// xcfr_out_stage
// Result register: holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xcfr_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  xcfr_pkg::result_t res,
  output logic              free,
  output logic              out_valid,
  input  logic              out_stall,
  output xcfr_pkg::result_t out_res
);
  import xcfr_pkg::*;

  logic    vld_r;
  logic    vld_nxt;
  result_t res_r;

  // Free when empty or when the held result leaves this cycle
  assign free    = !vld_r || !out_stall;
  assign vld_nxt = load || (vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Capture result payload
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_res   = res_r;

endmodule

@@ design/xor_checked_frame_receiver_core.sv @@
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver_core
// Length-prefixed frame receiver with running XOR check and tick timeout.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | in_operation, in_rx_byte
//  out     | out_valid / out_stall| out_byte_valid, out_byte, out_byte_index,
//          |                      | out_frame_done, out_frame_status
//  cfg     | cfg_we               | cfg_wdata (timeout_ticks)
//
// One item per cycle sustained while in_stall is low; an accepted item is held
// in the input register and processed from there, and its result passes through
// the result register to the out port. The input register and result register
// are each one deep; out_stall reaches in_stall only when the held item produces
// a result and the result register is full. Reset is synchronous and active low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xor_checked_frame_receiver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_byte_valid,
  output logic [7:0]  out_byte,
  output logic [8:0]  out_byte_index,
  output logic        out_frame_done,
  output logic [1:0]  out_frame_status,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import xcfr_pkg::*;

  logic [15:0] timeout_r;
  item_t       in_item;
  item_t       item;
  logic        item_vld;
  logic        fire;
  logic        res_has;
  result_t     res;
  logic        out_free;
  result_t     out_res;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  assign in_item.operation = in_operation;
  assign in_item.rx_byte   = in_rx_byte;

  // Consume the held item unless its result has nowhere to go
  assign fire = item_vld && (!res_has || out_free);

  xcfr_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .fire     (fire),
    .vld      (item_vld),
    .item     (item)
  );

  xcfr_engine u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .vld           (item_vld),
    .item          (item),
    .fire          (fire),
    .timeout_ticks (timeout_r),
    .res_has       (res_has),
    .res           (res)
  );

  xcfr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire && res_has),
    .res       (res),
    .free      (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte_valid   = out_res.byte_valid;
  assign out_byte         = out_res.out_byte;
  assign out_byte_index   = out_res.byte_index;
  assign out_frame_done   = out_res.frame_done;
  assign out_frame_status = out_res.frame_status;

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for xor_checked_frame_receiver_core. A short table of
// directed items covers idle bytes and ticks, the unused opcode, checksum
// errors, re-arm mid-frame and timeouts. Random framed traffic then runs
// under several timeout settings. A local model of the receiver predicts
// each result not typed in the table; random gaps and stalls hit both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import xcfr_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 9;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 950;
  localparam int N_PHASES     = 7;
  // Arm plus 257 bytes of the longest frame
  localparam int LONG_FRAME_ITEMS = 258;

  // Opcode with no function in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} chk_e;
  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    item_t       it;
    chk_e        chk;
    result_t     res;
    logic [15:0] cfg_val;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_operation = OP_ARM;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_byte_valid;
  logic [7:0]  out_byte;
  logic [8:0]  out_byte_index;
  logic        out_frame_done;
  logic [1:0]  out_frame_status;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = 16'd0;

  // Receiver model state and its copy of the timeout register
  logic        armed;
  logic [8:0]  rx_count;
  logic [7:0]  rx_length;
  logic [7:0]  rx_xor;
  logic [15:0] ticks_left;
  logic [15:0] timeout_ticks;

  result_t     expected_results[$];
  item_t       pending_items[$];
  dir_row_t    directed_rows[$];

  int          n_errors = 0;
  int          n_cycles = 0;
  int          n_items = 0;
  int          n_bytes_out = 0;
  int          n_ok = 0;
  int          n_checksum = 0;
  int          n_timeout = 0;
  int          n_settings = 0;
  bit          in_quiet = 1'b0;
  bit          out_quiet = 1'b0;
  int          out_hold = 0;

  xor_checked_frame_receiver_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte_valid   (out_byte_valid),
    .out_byte         (out_byte),
    .out_byte_index   (out_byte_index),
    .out_frame_done   (out_frame_done),
    .out_frame_status (out_frame_status),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles,
               expected_results.size());
      $display("FAIL xor_checked_frame_receiver_core");
      $finish;
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic int draw_wait(input bit quiet);
    if (quiet || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", n_cycles, what, got, want);
    n_errors++;
  endtask

  // Take results, compare them against the oldest expectation, then stall
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = {out_byte_valid, out_byte, out_byte_index, out_frame_done, out_frame_status};
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, index", int'(got.byte_index), -1);
        end else begin
          want = expected_results.pop_front();
          if (got.byte_valid !== want.byte_valid)
            report_mismatch("byte_valid", int'(got.byte_valid), int'(want.byte_valid));
          if (got.out_byte !== want.out_byte)
            report_mismatch("out_byte", int'(got.out_byte), int'(want.out_byte));
          if (got.byte_index !== want.byte_index)
            report_mismatch("byte_index", int'(got.byte_index), int'(want.byte_index));
          if (got.frame_done !== want.frame_done)
            report_mismatch("frame_done", int'(got.frame_done), int'(want.frame_done));
          if (got.frame_status !== want.frame_status)
            report_mismatch("frame_status", int'(got.frame_status), int'(want.frame_status));
          if (want.byte_valid) n_bytes_out++;
          if (want.frame_done) begin
            if (want.frame_status == ST_OK) n_ok++;
            else if (want.frame_status == ST_TIMEOUT) n_timeout++;
            else n_checksum++;
          end
        end
        if ($urandom_range(0, 49) == 0) out_quiet = !out_quiet;
        out_hold = draw_wait(out_quiet);
      end else if (out_hold > 0) begin
        out_hold--;
      end
      out_stall <= (out_hold > 0);
    end
  end

  // Advance the receiver model by one item; returns 1 when a result is due
  function automatic bit frame_rx_predict(input item_t it, output result_t r);
    logic [9:0] seen;
    r = '0;
    if (it.operation == OP_ARM) begin
      armed      = 1'b1;
      rx_count   = '0;
      rx_length  = '0;
      rx_xor     = '0;
      ticks_left = timeout_ticks;
      return 1'b0;
    end
    if (it.operation == OP_BYTE) begin
      if (!armed) return 1'b0;
      r.byte_valid = 1'b1;
      r.out_byte   = it.rx_byte;
      r.byte_index = rx_count;
      rx_xor = rx_xor ^ it.rx_byte;
      if (rx_count == 9'd1) rx_length = it.rx_byte;
      rx_count   = rx_count + 9'd1;
      ticks_left = timeout_ticks;
      seen = {1'b0, rx_count};
      if (seen >= 10'd2 && seen >= {2'b00, rx_length} + 10'd2) begin
        armed = 1'b0;
        r.frame_done   = 1'b1;
        r.frame_status = (rx_xor != 8'h00) ? ST_CHECKSUM : ST_OK;
      end
      return 1'b1;
    end
    // Tick: count down only while armed and a timeout is set
    if (it.operation == OP_TICK && armed && ticks_left != 16'd0) begin
      ticks_left = ticks_left - 16'd1;
      if (ticks_left == 16'd0) begin
        armed = 1'b0;
        r.byte_index   = rx_count;
        r.frame_done   = 1'b1;
        r.frame_status = ST_TIMEOUT;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Present one item after a random gap, hold it until taken, then predict
  task automatic send_item(input item_t it, input chk_e chk, input result_t typed);
    result_t r;
    bit      due;
    int      gap;
    if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= it.operation;
    in_rx_byte   <= it.rx_byte;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    due = frame_rx_predict(it, r);
    if (chk == CHK_TYPED) expected_results.push_back(typed);
    else if (chk == CHK_PREDICT && due) expected_results.push_back(r);
  endtask

  // Write the timeout register once the block has gone quiet
  task automatic write_timeout(input logic [15:0] v);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    timeout_ticks = v;
    n_settings++;
  endtask

  function automatic item_t mk_item(input logic [1:0] op, input logic [7:0] b);
    item_t it;
    it.operation = op;
    it.rx_byte   = b;
    return it;
  endfunction

  task automatic put_row(input logic [1:0] op, input logic [7:0] b, input chk_e chk,
                         input result_t res);
    dir_row_t row;
    row.kind    = ROW_ITEM;
    row.it      = mk_item(op, b);
    row.chk     = chk;
    row.res     = res;
    row.cfg_val = '0;
    directed_rows.push_back(row);
  endtask

  task automatic put_cfg(input logic [15:0] v);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_CFG;
    row.cfg_val = v;
    directed_rows.push_back(row);
  endtask

  task automatic build_directed();
    // Idle traffic and the unused opcode are dropped
    put_row(OP_TICK,   8'h00, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'hFF, CHK_NONE,    '0);
    put_row(OP_UNUSED, 8'hFF, CHK_NONE,    '0);
    // Zero-length frame with a bad checksum
    put_row(OP_ARM,    8'h00, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'hA5, CHK_TYPED,   {1'b1, 8'hA5, 9'd0, 1'b0, ST_OK});
    put_row(OP_BYTE,   8'h00, CHK_TYPED,   {1'b1, 8'h00, 9'd1, 1'b1, ST_CHECKSUM});
    // One payload byte, checksum clean
    put_row(OP_ARM,    8'hFF, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'h5A, CHK_PREDICT, '0);
    put_row(OP_BYTE,   8'h01, CHK_PREDICT, '0);
    put_row(OP_BYTE,   8'h5B, CHK_TYPED,   {1'b1, 8'h5B, 9'd2, 1'b1, ST_OK});
    // Re-arm mid-frame drops the partial frame
    put_row(OP_ARM,    8'h00, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'hFF, CHK_PREDICT, '0);
    put_row(OP_ARM,    8'h00, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'h00, CHK_TYPED,   {1'b1, 8'h00, 9'd0, 1'b0, ST_OK});
    put_row(OP_BYTE,   8'h00, CHK_TYPED,   {1'b1, 8'h00, 9'd1, 1'b1, ST_OK});
    // Shortest timeout: right after arm, then after one byte
    put_cfg(16'd1);
    put_row(OP_ARM,    8'h00, CHK_NONE,    '0);
    put_row(OP_TICK,   8'hFF, CHK_TYPED,   {1'b0, 8'h00, 9'd0, 1'b1, ST_TIMEOUT});
    put_row(OP_TICK,   8'h00, CHK_NONE,    '0);
    put_row(OP_ARM,    8'h00, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'h3C, CHK_PREDICT, '0);
    put_row(OP_TICK,   8'h00, CHK_TYPED,   {1'b0, 8'h00, 9'd1, 1'b1, ST_TIMEOUT});
    // Timeout disabled: ticks never end the frame
    put_cfg(16'd0);
    put_row(OP_ARM,    8'h00, CHK_NONE,    '0);
    put_row(OP_TICK,   8'h00, CHK_NONE,    '0);
    put_row(OP_TICK,   8'h00, CHK_NONE,    '0);
    put_row(OP_BYTE,   8'h7E, CHK_TYPED,   {1'b1, 8'h7E, 9'd0, 1'b0, ST_OK});
  endtask

  // Stray items of any opcode
  task automatic add_noise();
    int          k;
    int unsigned op;
    k = $urandom_range(1, 4);
    repeat (k) begin
      op = $urandom_range(0, 3);
      pending_items.push_back(mk_item(op[1:0], rand_byte()));
    end
  endtask

  // One framed exchange with random ticks; it may time out or be cut short
  task automatic gen_frame(input logic [15:0] tmo, input bit longest);
    int          len;
    int          t;
    int          cap;
    int          k;
    logic [7:0]  acc;
    logic [7:0]  b;
    int unsigned lb;
    acc = 8'h00;
    t   = int'(tmo);
    if (longest) len = 255;
    else if ($urandom_range(0, 3) == 0) len = $urandom_range(7, 40);
    else len = $urandom_range(0, 6);
    lb = len;
    cap = (t == 0) ? 20 : ((t - 1 < 6) ? t - 1 : 6);
    pending_items.push_back(mk_item(OP_ARM, rand_byte()));
    for (int i = 0; i < len + 2; i++) begin
      // Let the timer run out before this byte
      if (t != 0 && ((t <= 16 && $urandom_range(0, 99) < 6) ||
                     (t <= 128 && $urandom_range(0, 99) < 2))) begin
        repeat (t) pending_items.push_back(mk_item(OP_TICK, rand_byte()));
        if ($urandom_range(0, 1) == 0) add_noise();
        return;
      end
      // Keep the longest frame to its bytes alone
      if (!longest && $urandom_range(0, 3) == 0) begin
        k = $urandom_range(0, cap);
        repeat (k) pending_items.push_back(mk_item(OP_TICK, rand_byte()));
      end
      // Drop the rest; the next arm restarts reception
      if (i > 0 && !longest && $urandom_range(0, 99) < 2) return;
      if (i == 1) b = lb[7:0];
      else if (i == len + 1 && $urandom_range(0, 4) != 0) b = acc;
      else if (i == 0 && len == 0 && $urandom_range(0, 1) == 0) b = 8'h00;
      else b = rand_byte();
      acc = acc ^ b;
      pending_items.push_back(mk_item(OP_BYTE, b));
    end
  endtask

  initial begin
    logic [15:0] phase_tmo [N_PHASES];
    int          per_phase;
    int          base;
    int unsigned last_tmo;
    armed         = 1'b0;
    rx_count      = '0;
    rx_length     = '0;
    rx_xor        = '0;
    ticks_left    = '0;
    timeout_ticks = TIMEOUT_RESET;
    last_tmo      = $urandom_range(3, 16);
    phase_tmo = '{16'd1, 16'd2, 16'hFFFF, 16'd0, 16'd7, 16'd100, last_tmo[15:0]};
    per_phase = (RANDOM_ITEMS - LONG_FRAME_ITEMS) / N_PHASES;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    build_directed();
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_timeout(directed_rows[i].cfg_val);
      else send_item(directed_rows[i].it, directed_rows[i].chk, directed_rows[i].res);
    end

    // Random frames, one timeout setting per phase
    for (int p = 0; p < N_PHASES; p++) begin
      write_timeout(phase_tmo[p]);
      if (phase_tmo[p] == 16'hFFFF) gen_frame(phase_tmo[p], 1'b1);
      base = pending_items.size();
      while (pending_items.size() - base < per_phase) begin
        if ($urandom_range(0, 9) == 0) add_noise();
        else gen_frame(phase_tmo[p], 1'b0);
      end
      while (pending_items.size() > 0) send_item(pending_items.pop_front(), CHK_PREDICT, '0);
    end

    // Drain
    in_valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d items under %0d timeout settings, %0d bytes passed out",
             n_items, n_settings, n_bytes_out);
    $display("frames closed: %0d clean, %0d bad checksum, %0d timed out; %0d mismatches",
             n_ok, n_checksum, n_timeout, n_errors);
    if (n_errors == 0) begin
      $display("PASS xor_checked_frame_receiver_core");
    end else begin
      $display("FAIL xor_checked_frame_receiver_core");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/xcfr_pkg.sv
design/xcfr_in_stage.sv
design/xcfr_engine.sv
design/xcfr_out_stage.sv
design/xor_checked_frame_receiver_core.sv
verif/tb.sv
